FILE: hw/rtl/wrlm_pkg.sv
// wrlm_pkg: shared widths, constants and sequencer types for the rms level meter
// no dependencies; used by windowed_rms_level_meter
package wrlm_pkg;

    // default averaging window, in words
    localparam int WindowDefault = 200;

    // field and datapath widths
    localparam int SampleW = 16;
    localparam int LevelW  = 15;
    localparam int SqW     = 2 * LevelW;      // one squared magnitude, also the root radicand
    localparam int SumW    = 40;              // running sum of squares
    localparam int WinW    = 11;              // window sizes up to 1024 words
    localparam int UnitW   = LevelW + 2 + WinW; // shared trial-subtract width, window-weighted

    // iteration counts of the shared unit
    localparam int RootSteps = LevelW;        // two radicand bits per step
    localparam int CntW      = $clog2(RootSteps);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_UPDATE,
        ST_SQRT_MAG,
        ST_RMS_LOAD,
        ST_SQRT_RMS,
        ST_DONE
    } t_state;

    // operation of the shared trial-subtract unit
    typedef enum logic {
        OP_SCALED,
        OP_SQRT
    } t_unit_op;

endpackage

FILE: hw/rtl/wrlm_ram.sv
// wrlm_ram: generic single-write, single-read memory with registered read data
// no dependencies; holds the ring of squared magnitudes
module wrlm_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 200,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/windowed_rms_level_meter.sv
// windowed_rms_level_meter: moving-window rms meter with raw, sqrt and rms q15 levels
// depends on wrlm_pkg and wrlm_ram
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  sample   | in        | i_valid / o_stall  | i_sample (s16)
//  levels   | out       | o_valid / i_stall  | o_raw_level, o_sqrt_level, o_rms_level (u15)
//
// after the accepting edge the sequencer squares the magnitude and reads the ring, then
// writes the ring and updates the sum, takes the root of the magnitude, loads the sum,
// takes the window-weighted root of the sum and loads the output register, then returns
// to idle before it takes the next word. both roots run through one shared trial-subtract
// unit; the rms is the largest r with WINDOW*r*r <= sum, so no divide is needed. o_stall
// is high while a word is in work. synchronous active-low reset clears the sequencer, ring
// position and running sum; ring entries not yet written read as zero through a fill
// flag. a result held under i_stall holds the sequencer in its last state.
module windowed_rms_level_meter #(
    parameter int WINDOW = wrlm_pkg::WindowDefault
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [wrlm_pkg::SampleW-1:0] i_sample,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [wrlm_pkg::LevelW-1:0]         o_raw_level,
    output logic [wrlm_pkg::LevelW-1:0]         o_sqrt_level,
    output logic [wrlm_pkg::LevelW-1:0]         o_rms_level
);

    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SampleW = wrlm_pkg::SampleW;
    localparam int LevelW  = wrlm_pkg::LevelW;
    localparam int SqW     = wrlm_pkg::SqW;
    localparam int SumW    = wrlm_pkg::SumW;
    localparam int UnitW   = wrlm_pkg::UnitW;
    localparam int CntW    = wrlm_pkg::CntW;

    // control state
    wrlm_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_pos;
    logic             r_full;
    logic [SumW-1:0]  r_sum;
    logic             r_out_valid;

    // datapath registers
    logic [LevelW-1:0] r_mag;
    logic [SqW-1:0]    r_sq;
    logic [SqW-1:0]    r_work;
    logic [UnitW-1:0]  r_rem;
    logic [LevelW-1:0] r_root;
    logic [LevelW-1:0] r_sqrt_lvl;
    logic [CntW-1:0]   r_cnt;
    logic [LevelW-1:0] r_raw_out;
    logic [LevelW-1:0] r_sqrt_out;
    logic [LevelW-1:0] r_rms_out;

    // sequencer outputs
    logic               w_ram_re;
    logic               w_ram_we;
    wrlm_pkg::t_unit_op w_op;
    logic               w_last;
    logic               w_load_out;

    logic               w_accept;
    logic [SampleW-1:0] w_neg;
    logic [LevelW-1:0]  w_mag;
    logic [SqW-1:0]     w_old_sq;
    logic [SqW-1:0]     w_ram_rdata;
    logic [UnitW-1:0]   u_a;
    logic [UnitW-1:0]   u_b;
    logic [UnitW:0]     w_diff;
    logic               w_ge;
    logic [UnitW-1:0]   w_rem_next;

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != wrlm_pkg::ST_IDLE);

    // saturated magnitude of the sample
    assign w_neg = SampleW'(0) - SampleW'(i_sample);
    always_comb begin
        if (i_sample == SampleW'(16'sh8000)) begin
            w_mag = {LevelW{1'b1}};
        end else if (i_sample[SampleW-1]) begin
            w_mag = w_neg[LevelW-1:0];
        end else begin
            w_mag = i_sample[LevelW-1:0];
        end
    end

    // ring of squares
    wrlm_ram #(
        .WIDTH (SqW),
        .DEPTH (WINDOW),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_pos),
        .i_wdata (r_sq),
        .i_re    (w_ram_re),
        .i_raddr (r_pos),
        .o_rdata (w_ram_rdata)
    );

    // slots not yet written since reset count as zero
    assign w_old_sq = r_full ? w_ram_rdata : '0;

    // shared trial-subtract unit, plain or window-weighted root step
    always_comb begin
        u_a = {r_rem[UnitW-3:0], r_work[SqW-1 -: 2]};
        case (w_op)
            wrlm_pkg::OP_SCALED: begin
                u_b = UnitW'(WINDOW) * UnitW'({r_root, 2'b01});
            end
            default: begin
                u_b = UnitW'({r_root, 2'b01});
            end
        endcase
    end
    assign w_diff     = {1'b0, u_a} - {1'b0, u_b};
    assign w_ge       = !w_diff[UnitW];
    assign w_rem_next = w_ge ? w_diff[UnitW-1:0] : u_a;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wrlm_pkg::ST_IDLE:     if (w_accept) n_state = wrlm_pkg::ST_SQUARE;
            wrlm_pkg::ST_SQUARE:   n_state = wrlm_pkg::ST_UPDATE;
            wrlm_pkg::ST_UPDATE:   n_state = wrlm_pkg::ST_SQRT_MAG;
            wrlm_pkg::ST_SQRT_MAG: if (w_last) n_state = wrlm_pkg::ST_RMS_LOAD;
            wrlm_pkg::ST_RMS_LOAD: n_state = wrlm_pkg::ST_SQRT_RMS;
            wrlm_pkg::ST_SQRT_RMS: if (w_last) n_state = wrlm_pkg::ST_DONE;
            wrlm_pkg::ST_DONE:     if (w_load_out) n_state = wrlm_pkg::ST_IDLE;
            default:               n_state = wrlm_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_ram_re   = 1'b0;
        w_ram_we   = 1'b0;
        w_op       = wrlm_pkg::OP_SQRT;
        w_last     = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            wrlm_pkg::ST_SQUARE: begin
                w_ram_re = 1'b1;
            end
            wrlm_pkg::ST_UPDATE: begin
                w_ram_we = 1'b1;
            end
            wrlm_pkg::ST_SQRT_MAG: begin
                w_last = (r_cnt == CntW'(wrlm_pkg::RootSteps - 1));
            end
            wrlm_pkg::ST_SQRT_RMS: begin
                w_op   = wrlm_pkg::OP_SCALED;
                w_last = (r_cnt == CntW'(wrlm_pkg::RootSteps - 1));
            end
            wrlm_pkg::ST_DONE: begin
                w_load_out = !r_out_valid || !i_stall;
            end
            default: begin
                w_ram_re = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wrlm_pkg::ST_IDLE;
            r_pos       <= '0;
            r_full      <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == wrlm_pkg::ST_UPDATE) begin
                r_sum <= r_sum - SumW'(w_old_sq) + SumW'(r_sq);
                if (r_pos == AW'(WINDOW - 1)) begin
                    r_pos  <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_pos <= r_pos + AW'(1);
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            wrlm_pkg::ST_IDLE: begin
                if (w_accept) r_mag <= w_mag;
            end
            wrlm_pkg::ST_SQUARE: begin
                r_sq <= SqW'(r_mag) * SqW'(r_mag);
            end
            wrlm_pkg::ST_UPDATE: begin
                r_work <= {r_mag, {LevelW{1'b0}}};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            wrlm_pkg::ST_SQRT_MAG, wrlm_pkg::ST_SQRT_RMS: begin
                r_work <= {r_work[SqW-3:0], 2'b00};
                r_root <= {r_root[LevelW-2:0], w_ge};
                r_rem  <= w_rem_next;
                r_cnt  <= r_cnt + CntW'(1);
            end
            wrlm_pkg::ST_RMS_LOAD: begin
                // sum stays below WINDOW << 30, so its top bits alone give a zero root
                r_sqrt_lvl <= r_root;
                r_work     <= r_sum[SqW-1:0];
                r_rem      <= UnitW'(r_sum[SumW-1:SqW]);
                r_root     <= '0;
                r_cnt      <= '0;
            end
            wrlm_pkg::ST_DONE: begin
                if (w_load_out) begin
                    r_raw_out  <= r_mag;
                    r_sqrt_out <= r_sqrt_lvl;
                    r_rms_out  <= r_root;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_raw_level  = r_raw_out;
    assign o_sqrt_level = r_sqrt_out;
    assign o_rms_level  = r_rms_out;

    // ring position stays inside the window
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= AW'(WINDOW - 1))
        else $error("ring position beyond window");

    // running sum never exceeds a full window of full-scale squares
    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum < (SumW'(WINDOW) << SqW))
        else $error("running sum out of bound");

    // weighted root remainder stays below WINDOW times twice the partial root plus one
    a_rms_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wrlm_pkg::ST_SQRT_RMS)
        |-> (r_rem < UnitW'(WINDOW) * UnitW'({r_root, 1'b1})))
        else $error("weighted root remainder out of bound");

    // root remainder stays within twice the partial root
    a_root_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wrlm_pkg::ST_SQRT_MAG)
        |-> (r_rem <= UnitW'({r_root, 1'b0})))
        else $error("root remainder out of bound");

    // a finished word waiting under stall keeps the sequencer parked
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wrlm_pkg::ST_DONE && r_out_valid && i_stall)
        |=> (r_state == wrlm_pkg::ST_DONE))
        else $error("result dropped under stall");

endmodule
